// ----- hw/rtl/h264_fu_reassembler_defines.svh -----
// Assertion macros for the checker of the FU reassembler.
`ifndef H264_FU_REASSEMBLER_DEFINES_SVH
`define H264_FU_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define H264FU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define H264FU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/h264fu_pkg.sv -----
// Types, codes and helpers of the H.264 FU reassembler.
package h264fu_pkg;

	// NAL unit types the reassembler looks at
	localparam logic [4:0] TYPE_FU_A = 5'd28;
	localparam logic [4:0] TYPE_FU_B = 5'd29;
	localparam logic [4:0] TYPE_SPS  = 5'd7;
	localparam logic [4:0] TYPE_PPS  = 5'd8;

	// NAL header bits kept in the rebuilt byte, and the type field
	localparam logic [7:0] NAL_KEEP_MASK = 8'hE0;
	localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;

	// Plan queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_COMMIT  = 2'd1,
		KIND_DISCARD = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FLAG_NONE   = 2'd0,
		FLAG_FIRST  = 2'd1,
		FLAG_MIDDLE = 2'd2,
		FLAG_LAST   = 2'd3
	} flag_t;

	typedef enum logic [1:0] {
		POS_HDR     = 2'd0,
		POS_FU      = 2'd1,
		POS_PAYLOAD = 2'd2
	} pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
		logic       packet_end;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// What one input byte asks the back end to emit, in this order
	typedef struct packed {
		logic       pre_en;
		kind_t      pre_kind;
		logic       start;
		logic       data_en;
		logic [7:0] data;
		logic       end_en;
	} desc_t;

	function automatic logic is_fu(input logic [4:0] t);
		return (t == TYPE_FU_A) || (t == TYPE_FU_B);
	endfunction

endpackage

// ----- hw/rtl/h264fu_queue.sv -----
// Short plan queue that decouples the classifier from the beat sequencer.
module h264fu_queue
	import h264fu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output desc_t head_desc,
	output logic  empty
);

	desc_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_desc = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/h264fu_front.sv -----
// Front end: parses NAL and FU headers, tracks fragment state, plans output.
module h264fu_front
	import h264fu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     push,
	output desc_t    push_desc,
	input  logic     full
);

	pos_t       pos_q;
	logic [7:0] nal_q;
	logic [4:0] ptype_q;
	logic [4:0] prev_type_q;
	flag_t      prev_flag_q;
	logic       broken_q;
	logic       open_q;
	logic       fwd_q;
	logic       cae_q;

	pos_t       n_pos;
	logic [7:0] n_nal;
	logic [4:0] n_ptype;
	logic [4:0] n_prev_type;
	flag_t      n_prev_flag;
	logic       n_broken;
	logic       n_open;
	logic       n_fwd;
	logic       n_cae;
	desc_t      desc;
	logic [7:0] b;
	logic       accept;

	assign b         = in_data.data_byte;
	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign push_desc = desc;
	assign push      = accept && (desc.pre_en || desc.start || desc.data_en || desc.end_en);

	// Classify the byte and work out the next fragment state
	always_comb begin
		n_pos       = in_data.packet_start ? POS_HDR : pos_q;
		n_fwd       = in_data.packet_start ? 1'b0 : fwd_q;
		n_cae       = in_data.packet_start ? 1'b0 : cae_q;
		n_nal       = nal_q;
		n_ptype     = ptype_q;
		n_prev_type = prev_type_q;
		n_prev_flag = prev_flag_q;
		n_broken    = broken_q;
		n_open      = open_q;
		desc        = '0;

		unique case (n_pos)
			POS_HDR: begin
				n_fwd   = 1'b0;
				n_cae   = 1'b0;
				n_nal   = b;
				n_ptype = b[4:0];
				if (!is_fu(b[4:0]) && b[4:0] != TYPE_SPS && b[4:0] != TYPE_PPS) begin
					n_prev_type = b[4:0];
				end
				n_pos = POS_FU;
			end
			POS_FU: begin
				if (is_fu(ptype_q)) begin
					if (b[7]) begin
						// start fragment: close the pending frame, open a new one
						if (!broken_q && prev_flag_q == FLAG_MIDDLE &&
							!is_fu(prev_type_q) && open_q) begin
							desc.pre_en   = 1'b1;
							desc.pre_kind = KIND_COMMIT;
						end else if (open_q) begin
							desc.pre_en   = 1'b1;
							desc.pre_kind = KIND_DISCARD;
						end
						n_broken    = 1'b0;
						n_prev_flag = FLAG_FIRST;
						n_prev_type = ptype_q;
						desc.start  = 1'b1;
						desc.data_en = 1'b1;
						desc.data   = (nal_q & NAL_KEEP_MASK) ^ (b & NAL_TYPE_MASK);
						n_open      = 1'b1;
						n_fwd       = 1'b1;
						n_cae       = 1'b0;
					end else if (!b[6]) begin
						// middle fragment
						if (!broken_q && prev_flag_q != FLAG_NONE) begin
							if (prev_flag_q == FLAG_LAST || !is_fu(prev_type_q)) begin
								n_broken = 1'b1;
								if (open_q) begin
									desc.pre_en   = 1'b1;
									desc.pre_kind = KIND_DISCARD;
									n_open        = 1'b0;
								end
							end else begin
								n_prev_flag = FLAG_MIDDLE;
								n_fwd       = 1'b1;
							end
						end
					end else begin
						// end fragment
						if (!broken_q && prev_flag_q != FLAG_NONE) begin
							if (!is_fu(prev_type_q)) begin
								n_broken = 1'b1;
								if (open_q) begin
									desc.pre_en   = 1'b1;
									desc.pre_kind = KIND_DISCARD;
									n_open        = 1'b0;
								end
							end else if (open_q) begin
								n_prev_flag = FLAG_LAST;
								n_fwd       = 1'b1;
								n_cae       = 1'b1;
							end
						end
					end
				end
				n_pos = POS_PAYLOAD;
			end
			POS_PAYLOAD: begin
				if (n_fwd) begin
					desc.data_en = 1'b1;
					desc.data    = b;
				end
			end
			default: begin
			end
		endcase

		// Close the packet, committing if the end fragment asked for it
		if (in_data.packet_end) begin
			if (n_cae) begin
				desc.end_en = 1'b1;
				n_open      = 1'b0;
			end
			n_cae = 1'b0;
			n_fwd = 1'b0;
			n_pos = POS_HDR;
		end
	end

	// Hold state until a byte is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HDR;
			nal_q       <= '0;
			ptype_q     <= '0;
			prev_type_q <= '0;
			prev_flag_q <= FLAG_NONE;
			broken_q    <= 1'b0;
			open_q      <= 1'b0;
			fwd_q       <= 1'b0;
			cae_q       <= 1'b0;
		end else if (accept) begin
			pos_q       <= n_pos;
			nal_q       <= n_nal;
			ptype_q     <= n_ptype;
			prev_type_q <= n_prev_type;
			prev_flag_q <= n_prev_flag;
			broken_q    <= n_broken;
			open_q      <= n_open;
			fwd_q       <= n_fwd;
			cae_q       <= n_cae;
		end
	end

endmodule

// ----- hw/rtl/h264fu_back.sv -----
// Back end: expands each plan into output beats through an output register.
module h264fu_back
	import h264fu_pkg::*;
#(
	parameter int START_CODE_LEN = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  desc_t     head_desc,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int SC_W = $clog2(START_CODE_LEN + 1);

	logic            w_valid_q;
	logic            w_pre_q;
	kind_t           w_pre_kind_q;
	logic [SC_W-1:0] w_sc_q;
	logic            w_data_en_q;
	logic [7:0]      w_data_q;
	logic            w_end_q;

	logic            n_pre;
	logic [SC_W-1:0] n_sc;
	logic            n_data_en;
	logic            n_end;
	out_item_t       beat;
	logic            fire;
	logic            done;
	logic            out_valid_q;
	out_item_t       out_data_q;

	assign fire      = w_valid_q && (!out_valid_q || out_ready);
	assign done      = fire && beat.last;
	assign pop       = !empty && (!w_valid_q || done);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Pick the next beat of the current plan
	always_comb begin
		n_pre     = w_pre_q;
		n_sc      = w_sc_q;
		n_data_en = w_data_en_q;
		n_end     = w_end_q;
		beat      = '0;
		priority if (w_pre_q) begin
			beat.kind = w_pre_kind_q;
			n_pre     = 1'b0;
		end else if (w_sc_q != '0) begin
			beat.kind     = KIND_BYTE;
			beat.out_byte = (w_sc_q == SC_W'(1)) ? 8'h01 : 8'h00;
			n_sc          = w_sc_q - 1'b1;
		end else if (w_data_en_q) begin
			beat.kind     = KIND_BYTE;
			beat.out_byte = w_data_q;
			n_data_en     = 1'b0;
		end else begin
			beat.kind = KIND_COMMIT;
			n_end     = 1'b0;
		end
		beat.last = !(n_pre || (n_sc != '0) || n_data_en || n_end);
	end

	// Load a plan or advance through it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_q <= 1'b0;
		end else if (pop) begin
			w_valid_q <= 1'b1;
		end else if (done) begin
			w_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			w_pre_q      <= head_desc.pre_en;
			w_pre_kind_q <= head_desc.pre_kind;
			w_sc_q       <= head_desc.start ? SC_W'(START_CODE_LEN) : '0;
			w_data_en_q  <= head_desc.data_en;
			w_data_q     <= head_desc.data;
			w_end_q      <= head_desc.end_en;
		end else if (fire) begin
			w_pre_q     <= n_pre;
			w_sc_q      <= n_sc;
			w_data_en_q <= n_data_en;
			w_end_q     <= n_end;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= beat;
		end
	end

endmodule

// ----- hw/rtl/h264_fu_reassembler.sv -----
// Top level of the H.264 FU-A/FU-B reassembler.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | data_byte, packet_start, packet_end
//  out     | output    | out_valid / out_ready| kind, out_byte, last
//
// One input byte is taken per cycle while the plan queue has room; a byte
// yields 0 to START_CODE_LEN + 2 beats, sent one per cycle by the back-end
// sequencer while out is not stalled, so a start fragment can hold the input
// once the queue fills. A byte's plan passes through the plan queue and the
// sequencer's plan register, and each beat through the output register.
// Reset clears the fragment state, the queue and the output register.
// Either side may stall; the queue and output register absorb it.
module h264_fu_reassembler
	import h264fu_pkg::*;
#(
	parameter int START_CODE_LEN = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic  push;
	desc_t push_desc;
	logic  full;
	logic  pop;
	desc_t head_desc;
	logic  empty;

	h264fu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_desc (push_desc),
		.full      (full)
	);

	h264fu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (full),
		.pop       (pop),
		.head_desc (head_desc),
		.empty     (empty)
	);

	h264fu_back #(
		.START_CODE_LEN (START_CODE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_desc (head_desc),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/h264fu_checker.sv -----
// Port-level checker for the FU reassembler, bound to the top level.
`include "h264_fu_reassembler_defines.svh"

module h264fu_checker
	import h264fu_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled result beat stays put
	`H264FU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out beat changed while stalled")

	// Only frame bytes carry a byte value
	`H264FU_ASSERT_NOW(a_ctrl_zero, out_valid && out_data.kind != KIND_BYTE, out_data.out_byte == 8'h00, "control beat with nonzero byte")

	// A commit or discard that is not last is followed at once by a start code zero
	`H264FU_ASSERT_NEXT(a_pre_then_sc, out_valid && out_ready && !out_data.last && (out_data.kind == KIND_COMMIT || out_data.kind == KIND_DISCARD), out_valid && out_data.kind == KIND_BYTE && out_data.out_byte == 8'h00, "start code does not follow frame close")

	// A taken 01 byte beat that is not the last beat of its byte is followed at once by another beat
	`H264FU_ASSERT_NEXT(a_sc_not_last, out_valid && out_ready && out_data.kind == KIND_BYTE && out_data.out_byte == 8'h01 && !out_data.last, out_valid, "start code sequence cut short")

endmodule

bind h264_fu_reassembler h264fu_checker u_checker (.*);
